FILE: design/adtp_pkg.sv
// Shared types, widths and constants for the ADC-average to PWM block.
// Used by the channel interfaces, the top level and the checker.
// No dependencies.
package adtp_pkg;

	// Field widths fixed by the item and result formats.
	localparam int SAMPLE_W = 10;
	localparam int NUM_SAMPLES = 4;
	localparam int SUM_W = 12;
	localparam int TOP_W = 16;
	localparam int DUTY_W = 7;
	localparam int SEG_W = 7;
	localparam int MUL_W = 7;
	localparam int PROD_W = TOP_W + MUL_W;
	localparam int CNT_W = 5;
	localparam int DIGIT_W = 4;

	// Reset value of the PWM period register.
	localparam logic [TOP_W-1:0] TOP_RESET = 16'd19999;

	// Duty and divisor constants.
	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
	localparam logic [MUL_W-1:0] PCT_SCALE = 7'd100;
	localparam logic [MUL_W-1:0] MUL_ONE = 7'd1;
	localparam logic [TOP_W-1:0] PCT_DIV = 16'd100;
	localparam logic [TOP_W-1:0] DEC_DIV = 16'd10;

	// Last step count of the serial multiply and of the serial divide.
	localparam logic [CNT_W-1:0] MUL_LAST = 5'(MUL_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = 5'(PROD_W - 1);

	// Item mode codes.
	localparam logic MODE_BATCH = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Digit enable codes, bit 0 low digit, bit 1 high digit.
	localparam logic [1:0] EN_LOW = 2'b01;
	localparam logic [1:0] EN_HIGH = 2'b10;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_NEXT = 5'b01000,
		ST_WAIT = 5'b10000
	} state_t;

	// Operations run on the shared multiply-divide unit.
	typedef enum logic [2:0] {
		OP_AVG,
		OP_DUTY,
		OP_CMPA,
		OP_CMPB,
		OP_DIGIT
	} op_t;

	// Seven-segment pattern for a decimal digit, bit 0 is segment a.
	// Codes above nine show blank.
	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0: p = 7'h3f;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5b;
			4'd3: p = 7'h4f;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6d;
			4'd6: p = 7'h7d;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7f;
			4'd9: p = 7'h6f;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

FILE: design/adtp_item_if.sv
// Input channel: a sample batch or a display refresh tick.
// Depends on adtp_pkg for the field widths.
interface adtp_item_if;
	import adtp_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	logic [SAMPLE_W-1:0] sample_0;
	logic [SAMPLE_W-1:0] sample_1;
	logic [SAMPLE_W-1:0] sample_2;
	logic [SAMPLE_W-1:0] sample_3;

	modport source (output valid, mode, sample_0, sample_1, sample_2, sample_3,
		input ready);
	modport sink (input valid, mode, sample_0, sample_1, sample_2, sample_3,
		output ready);
endinterface

FILE: design/adtp_result_if.sv
// Output channel: compare values, duty and display state after each item.
// Depends on adtp_pkg for the field widths.
interface adtp_result_if;
	import adtp_pkg::*;

	logic valid;
	logic ready;
	logic [TOP_W-1:0] compare_main;
	logic [TOP_W-1:0] compare_inverse;
	logic [DUTY_W-1:0] duty_percent;
	logic [SEG_W-1:0] segments;
	logic low_digit_enable;
	logic high_digit_enable;
	logic full_scale_led;

	modport source (output valid, compare_main, compare_inverse, duty_percent, segments,
		low_digit_enable, high_digit_enable, full_scale_led, input ready);
	modport sink (input valid, compare_main, compare_inverse, duty_percent, segments,
		low_digit_enable, high_digit_enable, full_scale_led, output ready);
endinterface

FILE: design/adc_to_pwm_with_bcd_display_top.sv
// ADC average to complementary PWM compare values, with a two-digit duty display.
// A batch result comes from four operations and a tick result from one; each result is then
// loaded into the output register. A new item is accepted only once the previous result has
// been loaded, which waits while an earlier result is still held unaccepted.
// All operations share one bit-serial shift-add multiplier and restoring divider.
// Reset (arst_n low, asynchronous) clears all state and sets the PWM period to 19999.
// Depends on adtp_pkg, adtp_item_if and adtp_result_if.
module adc_to_pwm_with_bcd_display_top #(
	parameter int SAMPLES_PER_BATCH = 4,
	parameter int ADC_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	adtp_item_if.sink item,
	adtp_result_if.source result,
	input logic cfg_we,
	input logic [adtp_pkg::TOP_W-1:0] cfg_wdata
);
	import adtp_pkg::*;

	// Number of samples summed and the ADC full-scale code.
	localparam int N_SUM = (SAMPLES_PER_BATCH > NUM_SAMPLES) ? NUM_SAMPLES :
		((SAMPLES_PER_BATCH < 1) ? 1 : SAMPLES_PER_BATCH);
	localparam logic [TOP_W:0] FULL_CODE = (17'd1 << ADC_BITS) - 17'd1;
	localparam logic [TOP_W-1:0] FULL_D = FULL_CODE[TOP_W-1:0];
	localparam logic [TOP_W-1:0] N_D = TOP_W'(N_SUM);

	state_t state_q;
	op_t op_q;
	logic [CNT_W-1:0] cnt_q;

	// Shared multiply-divide operands and working registers.
	logic [TOP_W-1:0] a_q;
	logic [MUL_W-1:0] m_q;
	logic [TOP_W-1:0] d_q;
	logic [PROD_W-1:0] prod_q;
	logic [TOP_W-1:0] rem_q;

	// Architectural state.
	logic [TOP_W-1:0] top_q;
	logic [DUTY_W-1:0] duty_q;
	logic [TOP_W-1:0] cmp_a_q;
	logic [TOP_W-1:0] cmp_b_q;
	logic show_low_q;
	logic [SEG_W-1:0] seg_q;
	logic [1:0] en_q;
	logic led_q;

	// Output register.
	logic out_valid_q;
	logic [TOP_W-1:0] out_cmp_a_q;
	logic [TOP_W-1:0] out_cmp_b_q;
	logic [DUTY_W-1:0] out_duty_q;
	logic [SEG_W-1:0] out_seg_q;
	logic [1:0] out_en_q;
	logic out_led_q;

	logic [SAMPLE_W-1:0] samp [NUM_SAMPLES];
	logic [SUM_W-1:0] sum;
	logic [DUTY_W-1:0] shown;
	logic [DUTY_W-1:0] duty_sat;
	logic [TOP_W:0] div_trial;
	logic [TOP_W:0] div_diff;
	logic div_ge;
	logic accept;

	// Sum of the samples that take part in the average.
	always_comb begin
		samp[0] = item.sample_0;
		samp[1] = item.sample_1;
		samp[2] = item.sample_2;
		samp[3] = item.sample_3;
		sum = '0;
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			if (i < N_SUM) begin
				sum = sum + SUM_W'(samp[i]);
			end
		end
	end

	// Duty shown on the display wraps 100 to 00; the duty saturates at 100.
	assign shown = (duty_q == DUTY_FULL) ? '0 : duty_q;
	assign duty_sat = (prod_q > PROD_W'(DUTY_FULL)) ? DUTY_FULL : prod_q[DUTY_W-1:0];

	// One restoring division step: the next product bit enters the remainder.
	assign div_trial = {rem_q, prod_q[PROD_W-1]};
	assign div_ge = (div_trial >= {1'b0, d_q});
	assign div_diff = div_trial - {1'b0, d_q};

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	// Sequencer, datapath and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_AVG;
			cnt_q <= '0;
			a_q <= '0;
			m_q <= '0;
			d_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			top_q <= TOP_RESET;
			duty_q <= '0;
			cmp_a_q <= '0;
			cmp_b_q <= '0;
			show_low_q <= 1'b0;
			seg_q <= '0;
			en_q <= '0;
			led_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_cmp_a_q <= '0;
			out_cmp_b_q <= '0;
			out_duty_q <= '0;
			out_seg_q <= '0;
			out_en_q <= '0;
			out_led_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			// The hand-over state reloads the output register itself.
			if (result.valid && result.ready && (state_q != ST_WAIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prod_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
						m_q <= MUL_ONE;
						state_q <= ST_MUL;
						if (item.mode == MODE_TICK) begin
							a_q <= TOP_W'(shown);
							d_q <= DEC_DIV;
							op_q <= OP_DIGIT;
						end else begin
							a_q <= TOP_W'(sum);
							d_q <= N_D;
							op_q <= OP_AVG;
						end
					end
				end
				ST_MUL: begin
					// Shift-add multiply, multiplier most significant bit first.
					prod_q <= {prod_q[PROD_W-2:0], 1'b0} +
						(m_q[MUL_W-1] ? PROD_W'(a_q) : '0);
					m_q <= {m_q[MUL_W-2:0], 1'b0};
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// The quotient bits replace the product bits from the bottom.
					prod_q <= {prod_q[PROD_W-2:0], div_ge};
					rem_q <= div_ge ? div_diff[TOP_W-1:0] : div_trial[TOP_W-1:0];
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						state_q <= ST_NEXT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_NEXT: begin
					// Take the quotient and set up the following operation.
					prod_q <= '0;
					rem_q <= '0;
					state_q <= ST_MUL;
					case (op_q)
						OP_AVG: begin
							a_q <= TOP_W'(prod_q[SAMPLE_W-1:0]);
							m_q <= PCT_SCALE;
							d_q <= FULL_D;
							op_q <= OP_DUTY;
						end
						OP_DUTY: begin
							duty_q <= duty_sat;
							a_q <= top_q;
							m_q <= duty_sat;
							d_q <= PCT_DIV;
							op_q <= OP_CMPA;
						end
						OP_CMPA: begin
							cmp_a_q <= prod_q[TOP_W-1:0];
							a_q <= top_q;
							m_q <= DUTY_FULL - duty_q;
							d_q <= PCT_DIV;
							op_q <= OP_CMPB;
						end
						OP_CMPB: begin
							cmp_b_q <= prod_q[TOP_W-1:0];
							state_q <= ST_WAIT;
						end
						OP_DIGIT: begin
							// Quotient is the tens digit, remainder the units digit.
							led_q <= (duty_q == DUTY_FULL);
							if (show_low_q) begin
								seg_q <= seg_pattern(rem_q[DIGIT_W-1:0]);
								en_q <= EN_LOW;
							end else begin
								seg_q <= seg_pattern(prod_q[DIGIT_W-1:0]);
								en_q <= EN_HIGH;
							end
							show_low_q <= !show_low_q;
							state_q <= ST_WAIT;
						end
						default: begin
							state_q <= ST_WAIT;
						end
					endcase
				end
				ST_WAIT: begin
					// Hand the state over once the output register is free.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_cmp_a_q <= cmp_a_q;
						out_cmp_b_q <= cmp_b_q;
						out_duty_q <= duty_q;
						out_seg_q <= seg_q;
						out_en_q <= en_q;
						out_led_q <= led_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result channel outputs.
	assign result.valid = out_valid_q;
	assign result.compare_main = out_cmp_a_q;
	assign result.compare_inverse = out_cmp_b_q;
	assign result.duty_percent = out_duty_q;
	assign result.segments = out_seg_q;
	assign result.low_digit_enable = out_en_q[0];
	assign result.high_digit_enable = out_en_q[1];
	assign result.full_scale_led = out_led_q;

endmodule

FILE: design/adtp_checker.sv
// Port-level checks on the result channel of the top level, and their bind.
// Depends on adtp_pkg and adc_to_pwm_with_bcd_display_top.
module adtp_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [adtp_pkg::DUTY_W-1:0] res_duty,
	input logic res_low_en,
	input logic res_high_en,
	input logic res_led
);
	import adtp_pkg::*;

	// A pending transaction stays offered until it is taken.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before the transaction completed");

	// At most one digit is selected at a time.
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_low_en && res_high_en))
		else $error("both digit enables are high");

	// The duty saturates at full scale.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_duty <= DUTY_FULL))
		else $error("duty percentage above full scale");

	// The full-scale lamp is only set by a refresh, which also selects a digit.
	a_led_digit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_led |-> (res_low_en || res_high_en))
		else $error("full-scale lamp lit with no digit selected");

endmodule

bind adc_to_pwm_with_bcd_display_top adtp_checker u_adtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_duty(result.duty_percent),
	.res_low_en(result.low_digit_enable),
	.res_high_en(result.high_digit_enable),
	.res_led(result.full_scale_led)
);
